@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker of the timer queue.
// Needs nothing else; each macro clocks on the given clock and holds off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is low.
`define OTQ_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define OTQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ rtl/otq_pkg.sv @@
// Package for the one-shot timer queue: sizes, command codes, cell and control types.
// Used by every other file of the block but the assertion macros; depends on nothing.
`default_nettype none

package otq_pkg;

  // Sizing
  localparam int TIMER_SLOTS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int CMD_W       = 3;
  localparam int ID_W        = 4;
  localparam int IN_CNT_W    = 32;
  localparam int OUT_CNT_W   = 32;

  typedef logic [CMD_W-1:0]      cmd_t;
  typedef logic [ID_W-1:0]       tid_t;
  typedef logic [COUNT_BITS-1:0] cnt_t;

  // Command codes carried on the input channel
  localparam cmd_t CMD_START = 3'd0;
  localparam cmd_t CMD_STOP  = 3'd1;
  localparam cmd_t CMD_TICK  = 3'd2;
  localparam cmd_t CMD_QUERY = 3'd3;
  localparam cmd_t CMD_POP   = 3'd4;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_INSERT,
    ST_DRAIN
  } state_t;

  // Operations broadcast to the pending chain
  typedef enum logic [2:0] {
    P_HOLD,
    P_REMOVE,
    P_INSERT,
    P_TICK,
    P_SHIFT
  } pend_op_t;

  // Operations broadcast to the expired chain
  typedef enum logic [1:0] {
    E_HOLD,
    E_REMOVE,
    E_PUSH,
    E_POP
  } exp_op_t;

  // Pending cell contents: absolute ticks left, sorted by deadline then age
  typedef struct packed {
    logic vld;
    tid_t id;
    cnt_t rem;
  } pend_cell_t;

  // Expired cell contents: one expired timer id
  typedef struct packed {
    logic vld;
    tid_t id;
  } exp_cell_t;

  typedef struct packed {
    pend_op_t op;
    tid_t     key;
    cnt_t     cnt;
  } pend_ctl_t;

  typedef struct packed {
    exp_op_t op;
    tid_t    key;
  } exp_ctl_t;

  // Chain status seen by the sequencer
  typedef struct packed {
    logic head_due;
    tid_t head_id;
    logic q_hit;
    cnt_t q_rem;
    logic fifo_vld;
    tid_t fifo_head;
  } chain_stat_t;

endpackage

`default_nettype wire

@@ rtl/otq_in_if.sv @@
// Input channel of the timer queue: valid/ready handshake plus command beat.
// Depends on otq_pkg for field types.
`default_nettype none

interface otq_in_if import otq_pkg::*; ();
  logic                valid;
  logic                ready;
  cmd_t                cmd;
  tid_t                timer_id;
  logic [IN_CNT_W-1:0] count;

  modport source (output valid, output cmd, output timer_id, output count, input ready);
  modport sink   (input valid, input cmd, input timer_id, input count, output ready);
endinterface

`default_nettype wire

@@ rtl/otq_out_if.sv @@
// Result channel of the timer queue: valid/ready handshake plus result beat.
// Depends on otq_pkg for field types.
`default_nettype none

interface otq_out_if import otq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 valid_res;
  tid_t                 expired_id;
  logic [OUT_CNT_W-1:0] ticks_left;

  modport source (output valid, output valid_res, output expired_id, output ticks_left,
                  input ready);
  modport sink   (input valid, input valid_res, input expired_id, input ticks_left,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/otq_pend_cell.sv @@
// One cell of the pending chain: holds a running timer and its absolute ticks left.
// Depends on otq_pkg; talks to its left and right neighbors every cycle.
`default_nettype none

module otq_pend_cell import otq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pend_ctl_t  ctl,
  input  pend_cell_t left,
  input  logic       left_keep,
  input  logic       left_hit,
  input  pend_cell_t right,
  output pend_cell_t cur,
  output logic       keep_o,
  output logic       hit_o,
  output logic       q_hit_o,
  output cnt_t       q_rem_o
);

  logic vld_r, vld_nxt;
  tid_t id_r, id_nxt;
  cnt_t rem_r, rem_nxt;
  logic match;

  // Neighbor flags: keep = expires no later than the new timer; hit = key at or before
  assign match   = vld_r && (id_r == ctl.key);
  assign keep_o  = vld_r && (rem_r <= ctl.cnt);
  assign hit_o   = left_hit || match;
  assign q_hit_o = match;
  assign q_rem_o = match ? rem_r : '0;
  assign cur     = '{vld: vld_r, id: id_r, rem: rem_r};

  // Cell update
  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    rem_nxt = rem_r;
    case (ctl.op)
      P_INSERT: begin
        if (!keep_o) begin
          if (left_keep) begin
            vld_nxt = 1'b1;
            id_nxt  = ctl.key;
            rem_nxt = ctl.cnt;
          end else begin
            vld_nxt = left.vld;
            id_nxt  = left.id;
            rem_nxt = left.rem;
          end
        end
      end
      P_REMOVE: begin
        if (hit_o) begin
          vld_nxt = right.vld;
          id_nxt  = right.id;
          rem_nxt = right.rem;
        end
      end
      P_TICK: begin
        if (vld_r) rem_nxt = rem_r - cnt_t'(1);
      end
      P_SHIFT: begin
        vld_nxt = right.vld;
        id_nxt  = right.id;
        rem_nxt = right.rem;
      end
      P_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r  <= id_nxt;
    rem_r <= rem_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/otq_exp_cell.sv @@
// One cell of the expired chain: holds one expired timer id, oldest at the head.
// Depends on otq_pkg; compacts toward the head on pop and on removal.
`default_nettype none

module otq_exp_cell import otq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  exp_ctl_t  ctl,
  input  logic      left_vld,
  input  logic      left_hit,
  input  exp_cell_t right,
  output exp_cell_t cur,
  output logic      hit_o
);

  logic vld_r, vld_nxt;
  tid_t id_r, id_nxt;

  assign hit_o = left_hit || (vld_r && (id_r == ctl.key));
  assign cur   = '{vld: vld_r, id: id_r};

  // Cell update: push lands in the first empty cell
  always_comb begin
    vld_nxt = vld_r;
    id_nxt  = id_r;
    case (ctl.op)
      E_PUSH: begin
        if (!vld_r && left_vld) begin
          vld_nxt = 1'b1;
          id_nxt  = ctl.key;
        end
      end
      E_POP: begin
        vld_nxt = right.vld;
        id_nxt  = right.id;
      end
      E_REMOVE: begin
        if (hit_o) begin
          vld_nxt = right.vld;
          id_nxt  = right.id;
        end
      end
      E_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/otq_ctrl.sv @@
// Command sequencer of the timer queue: takes a command beat, steps the two cell
// chains through it, and holds the result beat. Depends on otq_pkg and the channel interfaces.
`default_nettype none

module otq_ctrl import otq_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  otq_in_if.sink      in_ch,
  otq_out_if.source   out_ch,
  input  chain_stat_t stat,
  output pend_ctl_t   pend_ctl,
  output exp_ctl_t    exp_ctl
);

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r;
  tid_t                 id_r;
  cnt_t                 cnt_r;
  logic                 out_vld_r, out_vld_nxt;
  logic                 res_vld_r, res_vld_nxt;
  tid_t                 res_id_r, res_id_nxt;
  logic [OUT_CNT_W-1:0] res_left_r, res_left_nxt;
  logic                 finish;
  logic                 out_free;
  logic                 id_ok;
  logic                 accept;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_vld_r || out_ch.ready;
  assign id_ok       = (int'(id_r) < TIMER_SLOTS);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          if ((cmd_r == CMD_START) && id_ok) state_nxt = ST_INSERT;
          else if (cmd_r == CMD_TICK)        state_nxt = ST_DRAIN;
          else                               state_nxt = ST_IDLE;
        end
      end
      ST_INSERT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_DRAIN: begin
        if (out_free && !stat.head_due) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Chain controls and result
  always_comb begin
    pend_ctl.op  = P_HOLD;
    pend_ctl.key = id_r;
    pend_ctl.cnt = cnt_r;
    exp_ctl.op   = E_HOLD;
    exp_ctl.key  = id_r;
    finish       = 1'b0;
    res_vld_nxt  = 1'b0;
    res_id_nxt   = '0;
    res_left_nxt = '0;
    case (state_r)
      ST_EXEC: begin
        if (out_free) begin
          case (cmd_r)
            CMD_START: begin
              // a busy timer is stopped before it is armed again
              if (id_ok) begin
                pend_ctl.op = P_REMOVE;
                exp_ctl.op  = E_REMOVE;
              end else begin
                finish = 1'b1;
              end
            end
            CMD_STOP: begin
              if (id_ok) begin
                pend_ctl.op = P_REMOVE;
                exp_ctl.op  = E_REMOVE;
              end
              finish = 1'b1;
            end
            CMD_TICK: begin
              pend_ctl.op = P_TICK;
            end
            CMD_QUERY: begin
              finish       = 1'b1;
              res_vld_nxt  = stat.q_hit;
              res_id_nxt   = id_r;
              res_left_nxt = OUT_CNT_W'(stat.q_rem);
            end
            CMD_POP: begin
              finish = 1'b1;
              if (stat.fifo_vld) begin
                exp_ctl.op  = E_POP;
                res_vld_nxt = 1'b1;
                res_id_nxt  = stat.fifo_head;
              end
            end
            default: begin
              finish = 1'b1;
            end
          endcase
        end
      end
      ST_INSERT: begin
        if (out_free) begin
          finish = 1'b1;
          if (cnt_r == '0) exp_ctl.op = E_PUSH;
          else             pend_ctl.op = P_INSERT;
        end
      end
      ST_DRAIN: begin
        // move due timers from the head, one per cycle while the result register is free, in list order
        if (out_free) begin
          if (stat.head_due) begin
            pend_ctl.op = P_SHIFT;
            exp_ctl.op  = E_PUSH;
            exp_ctl.key = stat.head_id;
          end else begin
            finish = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_vld_nxt = finish ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Command and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.cmd;
      id_r  <= in_ch.timer_id;
      cnt_r <= COUNT_BITS'(in_ch.count);
    end
    if (finish) begin
      res_vld_r  <= res_vld_nxt;
      res_id_r   <= res_id_nxt;
      res_left_r <= res_left_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.valid_res  = res_vld_r;
  assign out_ch.expired_id = res_id_r;
  assign out_ch.ticks_left = res_left_r;

endmodule

`default_nettype wire

@@ rtl/one_shot_timer_queue_top.sv @@
// Top level of the one-shot timer queue: sequencer plus the pending and expired cell chains.
// Depends on otq_pkg, otq_in_if, otq_out_if, otq_ctrl, otq_pend_cell and otq_exp_cell.
`default_nettype none

// One command is taken at a time and gives exactly one result beat. Stop, query,
// pop and unknown commands finish in the execute state that follows acceptance,
// which then registers their result beat. A start with a valid slot also passes
// through the insert state (stop the old entry, then insert or expire at once); a
// tick passes through the drain state, where the pending chain hands its due head to
// the expired chain one cell per cycle while the result register is free.
// The next command is accepted as soon as the sequencer is idle, even while the last
// result still waits; a command that finds the result register full waits there
// until it is taken.
// Running timers sit in a row of cells sorted by deadline (ties in arrival order),
// each holding its own ticks left; expired ids sit in a second row, oldest first.
module one_shot_timer_queue_top import otq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  otq_in_if.sink    in_ch,
  otq_out_if.source out_ch
);

  pend_ctl_t   pend_ctl;
  exp_ctl_t    exp_ctl;
  chain_stat_t stat;

  pend_cell_t  pc     [TIMER_SLOTS];
  logic        pkeep  [TIMER_SLOTS];
  logic        phit   [TIMER_SLOTS];
  logic        pq_hit [TIMER_SLOTS];
  cnt_t        pq_rem [TIMER_SLOTS];
  exp_cell_t   ec     [TIMER_SLOTS];
  logic        ehit   [TIMER_SLOTS];

  otq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .stat     (stat),
    .pend_ctl (pend_ctl),
    .exp_ctl  (exp_ctl)
  );

  // Pending chain, cell 0 is the next to expire
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_pend
    pend_cell_t left_c, right_c;
    logic       left_keep, left_hit;
    if (i == 0) begin : g_first
      assign left_c    = '0;
      assign left_keep = 1'b1;
      assign left_hit  = 1'b0;
    end else begin : g_inner
      assign left_c    = pc[i-1];
      assign left_keep = pkeep[i-1];
      assign left_hit  = phit[i-1];
    end
    if (i == TIMER_SLOTS - 1) begin : g_last
      assign right_c = '0;
    end else begin : g_body
      assign right_c = pc[i+1];
    end
    otq_pend_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (pend_ctl),
      .left      (left_c),
      .left_keep (left_keep),
      .left_hit  (left_hit),
      .right     (right_c),
      .cur       (pc[i]),
      .keep_o    (pkeep[i]),
      .hit_o     (phit[i]),
      .q_hit_o   (pq_hit[i]),
      .q_rem_o   (pq_rem[i])
    );
  end

  // Expired chain, cell 0 is the oldest
  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_exp
    exp_cell_t right_c;
    logic      left_vld, left_hit;
    if (i == 0) begin : g_first
      assign left_vld = 1'b1;
      assign left_hit = 1'b0;
    end else begin : g_inner
      assign left_vld = ec[i-1].vld;
      assign left_hit = ehit[i-1];
    end
    if (i == TIMER_SLOTS - 1) begin : g_last
      assign right_c = '0;
    end else begin : g_body
      assign right_c = ec[i+1];
    end
    otq_exp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (exp_ctl),
      .left_vld (left_vld),
      .left_hit (left_hit),
      .right    (right_c),
      .cur      (ec[i]),
      .hit_o    (ehit[i])
    );
  end

  // Status for the sequencer; at most one pending cell matches a query
  always_comb begin
    stat.q_hit = 1'b0;
    stat.q_rem = '0;
    for (int k = 0; k < TIMER_SLOTS; k++) begin
      stat.q_hit = stat.q_hit | pq_hit[k];
      stat.q_rem = stat.q_rem | pq_rem[k];
    end
    stat.head_due  = pc[0].vld && (pc[0].rem == '0);
    stat.head_id   = pc[0].id;
    stat.fifo_vld  = ec[0].vld;
    stat.fifo_head = ec[0].id;
  end

endmodule

`default_nettype wire

@@ rtl/otq_checker.sv @@
// Port-level checker for the timer queue, bound to the top level below.
// Depends on otq_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module otq_port_checker import otq_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_valid_res,
  input tid_t                 out_expired_id,
  input logic [OUT_CNT_W-1:0] out_ticks_left
);

  logic [2:0] pend_r, pend_nxt;

  // Commands taken whose result beat is not yet delivered
  always_comb begin
    pend_nxt = pend_r;
    if (in_valid && in_ready)   pend_nxt = pend_nxt + 3'd1;
    if (out_valid && out_ready) pend_nxt = pend_nxt - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 3'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `OTQ_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_valid_res) && $stable(out_expired_id) && $stable(out_ticks_left), "stalled result beat changed")
  `OTQ_ASSERT_NEXT(a_one_cmd, clk, rst_n, in_valid && in_ready, !in_ready, "second command taken while busy")
  `OTQ_ASSERT(a_no_extra, clk, rst_n, out_valid |-> (pend_r != 3'd0), "result beat without a command")
  `OTQ_ASSERT(a_bound, clk, rst_n, pend_r <= 3'd2, "more than two commands in flight")
  `OTQ_ASSERT(a_zero_left, clk, rst_n, (out_valid && !out_valid_res) |-> (out_ticks_left == '0), "ticks left on an empty result")

endmodule

bind one_shot_timer_queue_top otq_port_checker u_otq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_valid_res  (out_ch.valid_res),
  .out_expired_id (out_ch.expired_id),
  .out_ticks_left (out_ch.ticks_left)
);

`default_nettype wire

@@ verif/otq_checker.sv @@
// Checker for the one-shot timer queue: watches both channels, predicts every result beat.
// Depends on otq_pkg, otq_in_if and otq_out_if; reports an error count to the test top.

module otq_checker import otq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  otq_in_if    in_mon,
  otq_out_if   out_mon,
  output int   err_count,
  output int   outstanding,
  output int   results_checked
);

  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {
    SLOT_IDLE,
    SLOT_RUN,
    SLOT_EXP
  } slot_state_t;

  // One entry of the deadline list: ticks left after the entry in front of it
  typedef struct packed {
    tid_t        id;
    logic [63:0] delta;
  } delta_cell_t;

  typedef struct packed {
    logic                 vld;
    tid_t                 id;
    logic [OUT_CNT_W-1:0] left;
  } timer_result_t;

  delta_cell_t   deadline_list[$];
  tid_t          expired_ids[$];
  slot_state_t   slot_state[TIMER_SLOTS];
  timer_result_t due_results[$];
  int            mismatches;
  int            checked;

  function automatic void clear_timers();
    deadline_list.delete();
    expired_ids.delete();
    due_results.delete();
    foreach (slot_state[k]) slot_state[k] = SLOT_IDLE;
  endfunction

  // Mark a slot expired behind the older expiries
  function automatic void expire_slot(tid_t id);
    if (expired_ids.size() < TIMER_SLOTS) expired_ids.push_back(id);
    slot_state[id] = SLOT_EXP;
  endfunction

  // Pull a slot out of whichever list holds it; the next cell inherits its delta
  function automatic void cancel_slot(tid_t id);
    int          hit;
    delta_cell_t nxt;
    hit = -1;
    if (slot_state[id] == SLOT_RUN) begin
      foreach (deadline_list[k])
        if (hit < 0 && deadline_list[k].id == id) hit = k;
      if (hit >= 0) begin
        if (hit + 1 < deadline_list.size()) begin
          nxt = deadline_list[hit+1];
          nxt.delta += deadline_list[hit].delta;
          deadline_list[hit+1] = nxt;
        end
        deadline_list.delete(hit);
      end
    end else if (slot_state[id] == SLOT_EXP) begin
      foreach (expired_ids[k])
        if (hit < 0 && expired_ids[k] == id) hit = k;
      if (hit >= 0) expired_ids.delete(hit);
    end
    slot_state[id] = SLOT_IDLE;
  endfunction

  // Arm a slot; zero expires at once, equal deadlines queue behind older ones
  function automatic void arm_slot(tid_t id, cnt_t cnt);
    logic [63:0] rem;
    int          pos;
    delta_cell_t entry;
    rem = 64'(cnt);
    pos = -1;
    if (slot_state[id] != SLOT_IDLE) cancel_slot(id);
    if (rem == 0) begin
      expire_slot(id);
      return;
    end
    if (deadline_list.size() >= TIMER_SLOTS) return;
    foreach (deadline_list[k])
      if (pos < 0) begin
        if (deadline_list[k].delta <= rem) rem -= deadline_list[k].delta;
        else pos = k;
      end
    if (pos < 0) begin
      pos = deadline_list.size();
    end else begin
      entry = deadline_list[pos];
      entry.delta -= rem;
      deadline_list[pos] = entry;
    end
    entry.id    = id;
    entry.delta = rem;
    deadline_list.insert(pos, entry);
    slot_state[id] = SLOT_RUN;
  endfunction

  // Count the head down; a head at zero takes every zero-delta follower with it
  function automatic void tick_timers();
    delta_cell_t head;
    if (deadline_list.size() == 0) return;
    head = deadline_list[0];
    if (head.delta != 0) head.delta--;
    deadline_list[0] = head;
    if (head.delta != 0) return;
    while (deadline_list.size() > 0 && deadline_list[0].delta == 0) begin
      expire_slot(deadline_list[0].id);
      void'(deadline_list.pop_front());
    end
  endfunction

  function automatic timer_result_t timer_result(cmd_t cmd, tid_t id,
                                                 logic [IN_CNT_W-1:0] count);
    timer_result_t r;
    logic [63:0]   sum;
    logic          found;
    r     = '0;
    sum   = '0;
    found = 1'b0;
    case (cmd)
      CMD_START: arm_slot(id, cnt_t'(count));
      CMD_STOP:  cancel_slot(id);
      CMD_TICK:  tick_timers();
      CMD_QUERY: begin
        r.id = id;
        if (slot_state[id] == SLOT_RUN) begin
          // absolute time left is the sum of deltas up to and including this slot
          foreach (deadline_list[k])
            if (!found) begin
              sum += deadline_list[k].delta;
              if (deadline_list[k].id == id) found = 1'b1;
            end
          r.vld  = 1'b1;
          r.left = sum[OUT_CNT_W-1:0];
        end
      end
      CMD_POP: begin
        if (expired_ids.size() > 0) begin
          r.id = expired_ids.pop_front();
          slot_state[r.id] = SLOT_IDLE;
          r.vld = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Result beats are handled before command beats: a result leaving now is never
  // caused by the command accepted on the same edge.
  always @(posedge clk) begin : watch
    timer_result_t want;
    if (!rst_n) begin
      clear_timers();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("ERROR: result beat %0d with no command waiting: vld=%0b id=%0d left=%0d",
                     checked, out_mon.valid_res, out_mon.expired_id, out_mon.ticks_left);
        end else begin
          want = due_results.pop_front();
          if (out_mon.valid_res !== want.vld || out_mon.expired_id !== want.id ||
              out_mon.ticks_left !== want.left) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("ERROR: result beat %0d: exp vld=%0b id=%0d left=%0d, got vld=%0b id=%0d left=%0d",
                       checked, want.vld, want.id, want.left,
                       out_mon.valid_res, out_mon.expired_id, out_mon.ticks_left);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        due_results.push_back(timer_result(in_mon.cmd, in_mon.timer_id, in_mon.count));
    end
    err_count       <= mismatches;
    outstanding     <= due_results.size();
    results_checked <= checked;
  end

endmodule

@@ verif/one_shot_timer_queue_top_test.sv @@
// Test top for the one-shot timer queue: clock, reset, command stimulus and verdict.
// Depends on otq_pkg, otq_in_if, otq_out_if, otq_checker and the block's top level.

module one_shot_timer_queue_top_test;
  import otq_pkg::*;

  localparam int   ITEMS_PER_PHASE = 475;
  localparam int   LONG_HOLD       = 300;
  localparam int   TAIL_CYCLES     = 40;
  localparam int   CYCLE_LIMIT     = 500000;
  localparam cmd_t CMD_RSVD_LO     = 3'd5;
  localparam cmd_t CMD_RSVD_MID    = 3'd6;
  localparam cmd_t CMD_RSVD_HI     = 3'd7;
  localparam logic [IN_CNT_W-1:0] COUNT_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct;
  int   stall_pct;
  int   hold_seq;
  int   hold_seen;
  int   beats_sent;
  int   cycles = 0;
  int   err_count;
  int   outstanding;
  int   results_checked;
  int   idle_by_phase[4]  = '{0, 45, 0, 11};
  int   stall_by_phase[4] = '{0, 0, 45, 11};

  otq_in_if  in_ch();
  otq_out_if out_ch();

  one_shot_timer_queue_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  otq_checker u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .err_count       (err_count),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still due", cycles, outstanding);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off each time hold_seq moves
  initial begin : sink_side
    int k;
    hold_seen = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        out_ch.ready <= 1'b0;
        for (k = 0; k < LONG_HOLD; k++) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one command beat and return on the edge that takes it
  task automatic send_beat(cmd_t c, tid_t id, logic [IN_CNT_W-1:0] cnt);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.cmd      <= c;
    in_ch.timer_id <= id;
    in_ch.count    <= cnt;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly short counts so timers expire, ties and immediate expiry come up often
  function automatic logic [IN_CNT_W-1:0] pick_count();
    int r;
    r = $urandom_range(99);
    if (r < 10)      return '0;
    else if (r < 65) return IN_CNT_W'($urandom_range(8, 1));
    else if (r < 85) return IN_CNT_W'($urandom_range(64, 9));
    else if (r < 92) return COUNT_MAX - IN_CNT_W'($urandom_range(3));
    else             return IN_CNT_W'($urandom());
  endfunction

  task automatic send_random();
    int   r;
    cmd_t c;
    r = $urandom_range(99);
    if (r < 35)      c = CMD_START;
    else if (r < 43) c = CMD_STOP;
    else if (r < 70) c = CMD_TICK;
    else if (r < 85) c = CMD_QUERY;
    else if (r < 97) c = CMD_POP;
    else             c = cmd_t'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
    send_beat(c, tid_t'($urandom_range(TIMER_SLOTS-1)), pick_count());
  endtask

  initial begin : stimulus
    int ph;
    int n;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.cmd      <= CMD_TICK;
    in_ch.timer_id <= '0;
    in_ch.count    <= '0;
    stall_pct      <= 0;
    hold_seq       <= 0;
    idle_pct   = 0;
    beats_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pop, idle tick/query/stop, zero and max counts, ties,
    // restart of a running slot, stop of running and expired slots, bad codes
    send_beat(CMD_POP,   4'd0,  '0);
    send_beat(CMD_TICK,  4'd0,  '0);
    send_beat(CMD_QUERY, 4'd0,  '0);
    send_beat(CMD_STOP,  4'd3,  '0);
    send_beat(CMD_START, 4'd0,  '0);
    send_beat(CMD_START, 4'd15, COUNT_MAX);
    send_beat(CMD_QUERY, 4'd15, '0);
    send_beat(CMD_START, 4'd1,  32'd2);
    send_beat(CMD_START, 4'd2,  32'd2);
    send_beat(CMD_START, 4'd3,  32'd1);
    send_beat(CMD_START, 4'd4,  32'd3);
    send_beat(CMD_QUERY, 4'd4,  '0);
    send_beat(CMD_START, 4'd4,  32'd2);
    send_beat(CMD_TICK,  4'd0,  '0);
    send_beat(CMD_TICK,  4'd0,  '0);
    send_beat(CMD_STOP,  4'd2,  '0);
    send_beat(CMD_POP,   4'd0,  '0);
    send_beat(CMD_POP,   4'd0,  '0);
    send_beat(CMD_STOP,  4'd15, '0);
    send_beat(CMD_QUERY, 4'd15, '0);
    send_beat(CMD_RSVD_LO,  4'd15, COUNT_MAX);
    send_beat(CMD_RSVD_MID, 4'd15, COUNT_MAX);
    send_beat(CMD_RSVD_HI,  4'd15, COUNT_MAX);
    send_beat(CMD_POP,   4'd0,  '0);
    send_beat(CMD_POP,   4'd0,  '0);
    send_beat(CMD_POP,   4'd0,  '0);
    drain_results();

    // Random phases with different pacing; a long output hold early in the first
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = idle_by_phase[ph];
      stall_pct <= stall_by_phase[ph];
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 0 && n == 60) hold_seq <= hold_seq + 1;
        send_random();
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Summary: %0d command beats sent, %0d result beats checked.",
             beats_sent, results_checked);
    $display("Covered four pacing phases, a long output hold-off and drain pauses.");
    if (err_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
